// File: design/pbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbg_pkg;

    localparam int unsigned SineW  = 16;
    localparam int unsigned StepW  = 30;
    localparam int unsigned PulseW = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned DiffW  = 31;
    localparam int unsigned CountW = 15;
    localparam int unsigned EnvW   = 15;
    localparam int unsigned WaveW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = StepW;

    localparam logic [SineW-1:0]  SineReset  = 16'd46341;
    localparam logic [StepW-1:0]  StepReset  = 30'd2;
    localparam logic [PulseW-1:0] PulseReset = 16'd480;

    // Bit position of the Q0.15 height inside the Q3.60 product.
    localparam int unsigned HeightLsb = 45;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SINE   = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_BOUNCE = 2'd2,
        CFG_PULSE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SineW-1:0]  sine;
        logic [StepW-1:0]  step;
        logic              bounce_en;
        logic [PulseW-1:0] pulse_len;
    } t_cfg;

    // Operands and flags handed from the state stage to the height stage.
    typedef struct packed {
        logic [TimeW-1:0] u;
        logic [DiffW-1:0] diff;
        logic             negate;
        logic             pulse;
    } t_stage;

endpackage

`default_nettype wire

// File: design/pbg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module pbg_cfg
    import pbg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sine      <= SineReset;
            r_cfg.step      <= StepReset;
            r_cfg.bounce_en <= 1'b0;
            r_cfg.pulse_len <= PulseReset;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SINE:   r_cfg.sine      <= i_cfg_data[SineW-1:0];
                CFG_STEP:   r_cfg.step      <= i_cfg_data[StepW-1:0];
                CFG_BOUNCE: r_cfg.bounce_en <= i_cfg_data[0];
                CFG_PULSE:  r_cfg.pulse_len <= i_cfg_data[PulseW-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/pbg_state.sv
`timescale 1ns / 1ps
`default_nettype none

module pbg_state
    import pbg_pkg::*;
#(
    parameter int unsigned MAX_BOUNCES = 16384
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_retrigger,
    output logic      o_s1_valid,
    input  wire logic i_s1_ready,
    output t_stage    o_s1
);

    localparam logic [CountW-1:0] MaxBounces = CountW'(MAX_BOUNCES);

    logic [TimeW-1:0]  r_norm_time, n_norm_time;
    logic              r_running, n_running;
    logic              r_rebounding, n_rebounding;
    logic [CountW-1:0] r_bounce_cnt, n_bounce_cnt;
    logic [PulseW-1:0] r_pulse_rem, n_pulse_rem;
    logic              r_s1_valid, n_s1_valid;
    t_stage            r_s1, n_s1;

    logic              accept;
    logic [DiffW-1:0]  two_s;
    logic              ground;
    logic [TimeW:0]    u_sum;
    logic [TimeW-1:0]  u_next;
    logic [CountW-1:0] bounce_inc;
    logic              pulse_on;

    assign o_in_ready = !r_s1_valid || i_s1_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign two_s  = {i_cfg.sine, 15'd0};
    assign ground = r_norm_time > {1'b0, two_s};
    assign u_sum  = {1'b0, r_norm_time} + {{(TimeW + 1 - StepW){1'b0}}, i_cfg.step};
    assign u_next = u_sum[TimeW] ? '1 : u_sum[TimeW-1:0];

    always_comb begin
        n_norm_time  = r_norm_time;
        n_running    = r_running;
        n_rebounding = r_rebounding;
        n_bounce_cnt = r_bounce_cnt;
        n_pulse_rem  = r_pulse_rem;
        n_s1.u       = r_norm_time;
        n_s1.diff    = '0;

        if (i_retrigger) begin
            n_running    = 1'b1;
            n_rebounding = 1'b0;
            n_bounce_cnt = '0;
            if (i_cfg.pulse_len > n_pulse_rem) begin
                n_pulse_rem = i_cfg.pulse_len;
            end
        end

        bounce_inc = n_bounce_cnt + 1'b1;

        if (n_running) begin
            n_norm_time = u_next;
            if (ground) begin
                if (i_cfg.pulse_len > n_pulse_rem) begin
                    n_pulse_rem = i_cfg.pulse_len;
                end
                if (i_cfg.bounce_en) begin
                    n_norm_time  = '0;
                    n_rebounding = 1'b1;
                    n_bounce_cnt = bounce_inc;
                    if (bounce_inc >= MaxBounces) begin
                        n_running    = 1'b0;
                        n_rebounding = 1'b0;
                        n_bounce_cnt = '0;
                    end
                end else begin
                    n_running    = 1'b0;
                    n_rebounding = 1'b0;
                    n_bounce_cnt = '0;
                end
            end else begin
                n_s1.diff = two_s - r_norm_time[DiffW-1:0];
            end
        end else begin
            n_norm_time  = '0;
            n_bounce_cnt = '0;
        end

        pulse_on = n_pulse_rem != '0;
        if (pulse_on) begin
            n_pulse_rem = n_pulse_rem - 1'b1;
        end

        n_s1.negate = n_rebounding && n_bounce_cnt[0];
        n_s1.pulse  = pulse_on;

        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (i_s1_ready) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_time  <= '0;
            r_running    <= 1'b0;
            r_rebounding <= 1'b0;
            r_bounce_cnt <= '0;
            r_pulse_rem  <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (accept) begin
                r_norm_time  <= n_norm_time;
                r_running    <= n_running;
                r_rebounding <= n_rebounding;
                r_bounce_cnt <= n_bounce_cnt;
                r_pulse_rem  <= n_pulse_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_bounce_cnt == '0) && !r_rebounding)
        else $error("bounce state left over while idle");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bounce_cnt < MaxBounces)
        else $error("bounce count reached the limit");

    a_pulse_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_retrigger |=>
            ({1'b0, r_pulse_rem} + 17'd1) >= {1'b0, $past(i_cfg.pulse_len)})
        else $error("trigger did not load the pulse counter");

endmodule

`default_nettype wire

// File: design/pbg_height.sv
`timescale 1ns / 1ps
`default_nettype none

module pbg_height
    import pbg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s1_valid,
    output logic                  o_s1_ready,
    input  t_stage                i_s1,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic signed [WaveW-1:0] o_wave_value,
    output logic [EnvW-1:0]       o_envelope_value,
    output logic                  o_zero_pulse
);

    logic [TimeW+DiffW-1:0] product;
    logic [EnvW-1:0]        height;
    logic [WaveW-1:0]       wave;

    logic                   r_valid;
    logic [WaveW-1:0]       r_wave;
    logic [EnvW-1:0]        r_env;
    logic                   r_pulse;
    logic                   load;

    // The product is a Q3.60 value; the height never reaches one.
    assign product = i_s1.u * i_s1.diff;
    assign height  = product[HeightLsb+EnvW-1:HeightLsb];
    assign wave    = i_s1.negate ? WaveW'(-{1'b0, height}) : {1'b0, height};

    assign o_s1_ready = !r_valid || i_out_ready;
    assign load       = i_s1_valid && o_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_wave  <= wave;
            r_env   <= height;
            r_pulse <= i_s1.pulse;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_wave_value     = r_wave;
    assign o_envelope_value = r_env;
    assign o_zero_pulse     = r_pulse;

    a_wave_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_wave == {1'b0, r_env})
            || (WaveW'(r_wave + {1'b0, r_env}) == '0))
        else $error("wave and envelope disagree");

endmodule

`default_nettype wire

// File: design/projectile_bounce_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_retrigger
// out       output     o_out_valid / i_out_ready   o_wave_value, o_envelope_value,
//                                                  o_zero_pulse
// cfg       input      i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// One item per clock unless stalled; results go via the stage and output registers.
// The rate is set by the state update on acceptance and the single multiplier stage.
// Reset is synchronous and active low; configuration returns to its default values.
// A stalled output holds its result while one more item waits in the stage register.

module projectile_bounce_generator_top
    import pbg_pkg::*;
#(
    parameter int unsigned MAX_BOUNCES = 16384
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [CfgDataW-1:0]  i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_retrigger,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [WaveW-1:0]   o_wave_value,
    output logic [EnvW-1:0]           o_envelope_value,
    output logic                      o_zero_pulse
);

    t_cfg   cfg;
    t_stage s1;
    logic   s1_valid;
    logic   s1_ready;

    pbg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pbg_state #(
        .MAX_BOUNCES (MAX_BOUNCES)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_retrigger (i_retrigger),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1        (s1)
    );

    pbg_height u_height (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s1_valid       (s1_valid),
        .o_s1_ready       (s1_ready),
        .i_s1             (s1),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_wave_value     (o_wave_value),
        .o_envelope_value (o_envelope_value),
        .o_zero_pulse     (o_zero_pulse)
    );

endmodule

`default_nettype wire
